// ----- design/tpme_pkg.sv -----
package tpme_pkg;

  // Field widths
  localparam int SampleW  = 17;
  localparam int DiffW    = SampleW + 1;
  localparam int FracBits = 8;
  localparam int AccW     = SampleW + FracBits;

  // EMA gain in 1/256 units
  localparam int GainW     = 9;
  localparam int GainShift = 8;
  localparam int GainOne   = 1 << GainShift;

  // Median window
  localparam int WinSize = 3;
  localparam int SlotW   = $clog2(WinSize);

  // Stream packing
  localparam int InDataW  = ((2 * SampleW + 7) / 8) * 8;
  localparam int OutBitsW = 4 * SampleW + DiffW;
  localparam int OutDataW = ((OutBitsW + 7) / 8) * 8;
  localparam int OutUserW = 3;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = SampleW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEmaGain       = 3'd0,
    CfgAmbientMin    = 3'd1,
    CfgAmbientMax    = 3'd2,
    CfgObjectMin     = 3'd3,
    CfgObjectMax     = 3'd4,
    CfgSensorPresent = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StDisconnected = 2'd0,
    StInvalid      = 2'd1,
    StSeeded       = 2'd2,
    StTrusted      = 2'd3
  } status_e;

  // Register reset values
  localparam logic [GainW-1:0]          GainReset   = GainW'(64);
  localparam logic signed [SampleW-1:0] AmbMinReset = SampleW'(-4000);
  localparam logic signed [SampleW-1:0] AmbMaxReset = SampleW'(12500);
  localparam logic signed [SampleW-1:0] ObjMinReset = SampleW'(-7000);
  localparam logic signed [SampleW-1:0] ObjMaxReset = SampleW'(38000);

  // Per-channel filter control
  typedef struct packed {
    logic             seed;
    logic             update;
    logic [SlotW-1:0] slot;
    logic [GainW-1:0] gain;
  } chan_ctrl_t;

endpackage

// ----- design/tpme_channel.sv -----
module tpme_channel (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tpme_pkg::chan_ctrl_t                  ctrl_i,
  input  logic signed [tpme_pkg::SampleW-1:0]   sample_i,
  output logic signed [tpme_pkg::SampleW-1:0]   smooth_o
);
  import tpme_pkg::*;

  localparam int ProdW = AccW + GainW + 1;
  localparam int SumW  = ProdW + 1;

  logic signed [SampleW-1:0] win_q   [WinSize];
  logic signed [SampleW-1:0] win_d   [WinSize];
  logic signed [SampleW-1:0] win_upd [WinSize];
  logic signed [AccW-1:0]    acc_q, acc_d, acc_ema, target;
  logic signed [SampleW-1:0] med;
  logic signed [GainW:0]     gain_s, keep_s;
  logic signed [ProdW-1:0]   p_new, p_old;
  logic signed [SumW-1:0]    sum;

  function automatic logic signed [SampleW-1:0] median3(
    input logic signed [SampleW-1:0] a,
    input logic signed [SampleW-1:0] b,
    input logic signed [SampleW-1:0] c
  );
    logic signed [SampleW-1:0] lo, hi, m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  always_comb begin
    for (int i = 0; i < WinSize; i++) begin
      win_upd[i] = (ctrl_i.slot == SlotW'(i)) ? sample_i : win_q[i];
    end
    med    = median3(win_upd[0], win_upd[1], win_upd[2]);
    target = {med, {FracBits{1'b0}}};
    gain_s = $signed({1'b0, ctrl_i.gain});
    keep_s = $signed((GainW + 1)'(GainOne)) - gain_s;
    p_new  = ProdW'(gain_s) * ProdW'(target);
    p_old  = ProdW'(keep_s) * ProdW'(acc_q);
    sum    = SumW'(p_new) + SumW'(p_old);
    acc_ema = AccW'(sum >>> GainShift);

    acc_d = acc_q;
    for (int i = 0; i < WinSize; i++) begin
      win_d[i] = win_q[i];
    end
    if (ctrl_i.seed) begin
      acc_d = {sample_i, {FracBits{1'b0}}};
      for (int i = 0; i < WinSize; i++) begin
        win_d[i] = sample_i;
      end
    end else if (ctrl_i.update) begin
      acc_d = acc_ema;
      for (int i = 0; i < WinSize; i++) begin
        win_d[i] = win_upd[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      for (int i = 0; i < WinSize; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      acc_q <= acc_d;
      for (int i = 0; i < WinSize; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  // floor of the accumulator after this item
  assign smooth_o = acc_d[AccW-1:FracBits];

endmodule

// ----- design/temp_pair_median_ema_filter_unit.sv -----
// An item transferred on the input sits in the input register; its result is loaded
// into the result register when that register is empty or draining (later while the
// output stalls). Throughput: one item per cycle unless the output stalls; the input
// and result registers form a two-stage pipe.
// Reset (rst_ni low, asynchronous): both stages empty, filter unseeded, windows and
// accumulators zero, configuration registers at their documented defaults.
module temp_pair_median_ema_filter_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [tpme_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [tpme_pkg::CfgDataW-1:0]        cfg_data_i,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [16:0] raw_ambient, [33:17] raw_object, [39:34] zero
  input  logic [tpme_pkg::InDataW-1:0]         s_axis_tdata,
  // [0] sensor_error
  input  logic                                 s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [16:0] echo_ambient, [33:17] echo_object, [50:34] smoothed_ambient,
  // [67:51] smoothed_object, [85:68] object_over_ambient, [87:86] zero
  output logic [tpme_pkg::OutDataW-1:0]        m_axis_tdata,
  // [0] reading_valid, [2:1] filter_status
  output logic [tpme_pkg::OutUserW-1:0]        m_axis_tuser
);
  import tpme_pkg::*;

  // Configuration registers
  logic [GainW-1:0]          gain_q;
  logic signed [SampleW-1:0] amb_min_q, amb_max_q, obj_min_q, obj_max_q;
  logic                      present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= GainReset;
      amb_min_q <= AmbMinReset;
      amb_max_q <= AmbMaxReset;
      obj_min_q <= ObjMinReset;
      obj_max_q <= ObjMaxReset;
      present_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgEmaGain:       gain_q    <= cfg_data_i[GainW-1:0];
        CfgAmbientMin:    amb_min_q <= $signed(cfg_data_i[SampleW-1:0]);
        CfgAmbientMax:    amb_max_q <= $signed(cfg_data_i[SampleW-1:0]);
        CfgObjectMin:     obj_min_q <= $signed(cfg_data_i[SampleW-1:0]);
        CfgObjectMax:     obj_max_q <= $signed(cfg_data_i[SampleW-1:0]);
        CfgSensorPresent: present_q <= cfg_data_i[0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // Input register stage
  logic                      s1_valid_q;
  logic signed [SampleW-1:0] s1_amb_q, s1_obj_q;
  logic                      s1_err_q;
  logic                      adv;

  // The pair moves to the result register when that register is empty or being drained.
  assign adv           = s1_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_amb_q <= $signed(s_axis_tdata[SampleW-1:0]);
      s1_obj_q <= $signed(s_axis_tdata[2*SampleW-1:SampleW]);
      s1_err_q <= s_axis_tuser;
    end
  end

  // Filter control state
  logic             seeded_q, seeded_d;
  logic [SlotW-1:0] slot_q, slot_d, slot_eff;
  logic [GainW-1:0] gain_eff;
  logic             pair_ok, accept_pair;
  status_e          status_d;
  chan_ctrl_t       ctrl;

  always_comb begin
    // Reject flagged pairs and pairs outside either inclusive range.
    pair_ok = !s1_err_q
              && (s1_amb_q >= amb_min_q) && (s1_amb_q <= amb_max_q)
              && (s1_obj_q >= obj_min_q) && (s1_obj_q <= obj_max_q);
    accept_pair = present_q && pair_ok;

    // Gain of zero acts as one; anything above unity acts as unity.
    if (gain_q == '0) begin
      gain_eff = GainW'(1);
    end else if (gain_q > GainW'(GainOne)) begin
      gain_eff = GainW'(GainOne);
    end else begin
      gain_eff = gain_q;
    end

    slot_eff = (slot_q < SlotW'(WinSize)) ? slot_q : '0;

    if (!present_q) begin
      status_d = StDisconnected;
    end else if (!pair_ok) begin
      status_d = StInvalid;
    end else if (!seeded_q) begin
      status_d = StSeeded;
    end else begin
      status_d = StTrusted;
    end

    ctrl.seed   = adv && accept_pair && !seeded_q;
    ctrl.update = adv && accept_pair && seeded_q;
    ctrl.slot   = slot_eff;
    ctrl.gain   = gain_eff;

    seeded_d = seeded_q;
    slot_d   = slot_q;
    if (ctrl.seed) begin
      seeded_d = 1'b1;
      slot_d   = '0;
    end else if (ctrl.update) begin
      // advance the ring slot, wrapping at the window size
      slot_d = (slot_eff == SlotW'(WinSize - 1)) ? '0 : slot_eff + SlotW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= 1'b0;
      slot_q   <= '0;
    end else begin
      seeded_q <= seeded_d;
      slot_q   <= slot_d;
    end
  end

  // One filter per channel; each returns its floored value after this item.
  logic signed [SampleW-1:0] smooth_amb, smooth_obj;

  tpme_channel u_ambient (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (s1_amb_q),
    .smooth_o (smooth_amb)
  );

  tpme_channel u_object (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (s1_obj_q),
    .smooth_o (smooth_obj)
  );

  // Result register
  logic signed [DiffW-1:0] diff;
  assign diff = DiffW'(smooth_obj) - DiffW'(smooth_amb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= {{(OutDataW - OutBitsW){1'b0}}, diff, smooth_obj, smooth_amb,
                       s1_obj_q, s1_amb_q};
      m_axis_tuser <= {status_d, accept_pair};
    end
  end

  // Checks
  a_valid_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] ==
      ((m_axis_tuser[2:1] == StSeeded) || (m_axis_tuser[2:1] == StTrusted))))
    else $error("reading_valid disagrees with filter_status");

  a_seeded_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(seeded_q))
    else $error("seeded flag cleared outside reset");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < SlotW'(WinSize))
    else $error("write slot out of window range");

  a_seed_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && seeded_q) |-> (status_d != StSeeded))
    else $error("seeded status issued after filter was seeded");

  a_seed_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.seed |=> (seeded_q && (slot_q == '0)))
    else $error("seeding did not set the filter state");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import tpme_pkg::*;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd6;

  localparam int RandPhases = 12;
  localparam int PhaseItems = 128;
  localparam int FieldLo    = -(1 << (SampleW - 1));
  localparam int FieldHi    = (1 << (SampleW - 1)) - 1;
  localparam int GainMax    = (1 << GainW) - 1;
  localparam int RangeLim   = 40000;

  // One result transfer, unpacked into its fields.
  typedef struct packed {
    logic signed [SampleW-1:0] echo_amb;
    logic signed [SampleW-1:0] echo_obj;
    logic signed [SampleW-1:0] sm_amb;
    logic signed [SampleW-1:0] sm_obj;
    logic signed [DiffW-1:0]   delta;
    logic                      valid;
    status_e                   status;
  } reading_t;

  // One row of the directed table: a register write or a temperature pair.
  // Rows with fixed set carry a hand-written expectation.
  typedef struct packed {
    logic                      is_reg;
    logic [CfgIdxW-1:0]        reg_idx;
    logic [CfgDataW-1:0]       reg_val;
    logic signed [SampleW-1:0] amb;
    logic signed [SampleW-1:0] obj;
    logic                      err;
    logic                      fixed;
    reading_t                  want;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [16:0] raw_ambient, [33:17] raw_object, zero pad
  logic                s_axis_tuser;   // [0] sensor_error
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // echo_ambient, echo_object, smoothed_ambient,
                                       // smoothed_object, object_over_ambient, zero pad
  logic [OutUserW-1:0] m_axis_tuser;   // [0] reading_valid, [2:1] filter_status

  temp_pair_median_ema_filter_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the filter: register copies and filter state, updated in transfer
  // order so that each accepted pair yields the reading the block must return.
  // ---------------------------------------------------------------------------
  logic [GainW-1:0] gain_reg;
  int               amb_lo, amb_hi, obj_lo, obj_hi;
  logic             present;
  int               amb_win [WinSize];
  int               obj_win [WinSize];
  int               ring_slot;
  logic             primed;
  longint           amb_acc, obj_acc;

  reading_t pending_results[$];
  row_t     stim_rows[$];
  int       mismatches;
  int       burst_left;

  function automatic int med3(int a, int b, int c);
    if (a > b) return (b > c) ? b : ((a > c) ? c : a);
    return (a > c) ? a : ((b > c) ? c : b);
  endfunction

  // Blend the new median into the accumulator; the arithmetic shift floors.
  function automatic longint ema_step(longint acc, int med, int g);
    return (longint'(g) * (longint'(med) <<< FracBits) + longint'(GainOne - g) * acc)
           >>> GainShift;
  endfunction

  function automatic reading_t filter_predict(int amb, int obj, logic err);
    reading_t r;
    int       g;
    logic     ok;
    r.echo_amb = amb[SampleW-1:0];
    r.echo_obj = obj[SampleW-1:0];
    r.valid    = 1'b0;
    if (!present) begin
      r.status = StDisconnected;
    end else begin
      ok = !err && amb >= amb_lo && amb <= amb_hi && obj >= obj_lo && obj <= obj_hi;
      if (!ok) begin
        // Hold everything; the smoothed fields repeat the held accumulators.
        r.status = StInvalid;
      end else if (!primed) begin
        // First good pair fills both windows and seeds the averages.
        for (int i = 0; i < WinSize; i++) begin
          amb_win[i] = amb;
          obj_win[i] = obj;
        end
        amb_acc   = longint'(amb) <<< FracBits;
        obj_acc   = longint'(obj) <<< FracBits;
        ring_slot = 0;
        primed    = 1'b1;
        r.status  = StSeeded;
        r.valid   = 1'b1;
      end else begin
        // Gain 0 acts as 1, anything above unity acts as unity.
        g = int'(gain_reg);
        if (g == 0) g = 1;
        else if (g > GainOne) g = GainOne;
        amb_win[ring_slot] = amb;
        obj_win[ring_slot] = obj;
        ring_slot = (ring_slot == WinSize - 1) ? 0 : ring_slot + 1;
        amb_acc  = ema_step(amb_acc, med3(amb_win[0], amb_win[1], amb_win[2]), g);
        obj_acc  = ema_step(obj_acc, med3(obj_win[0], obj_win[1], obj_win[2]), g);
        r.status = StTrusted;
        r.valid  = 1'b1;
      end
    end
    r.sm_amb = SampleW'(amb_acc >>> FracBits);
    r.sm_obj = SampleW'(obj_acc >>> FracBits);
    r.delta  = DiffW'((obj_acc >>> FracBits) - (amb_acc >>> FracBits));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table builders.
  // ---------------------------------------------------------------------------
  function automatic void add_reg(logic [CfgIdxW-1:0] idx, int val);
    row_t r;
    r         = '0;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val[CfgDataW-1:0];
    stim_rows.push_back(r);
  endfunction

  function automatic void add_pair(int amb, int obj, logic err);
    row_t r;
    r     = '0;
    r.amb = amb[SampleW-1:0];
    r.obj = obj[SampleW-1:0];
    r.err = err;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_known(int amb, int obj, logic err, int sa, int so,
                                    logic valid, status_e st);
    row_t r;
    r               = '0;
    r.amb           = amb[SampleW-1:0];
    r.obj           = obj[SampleW-1:0];
    r.err           = err;
    r.fixed         = 1'b1;
    r.want.echo_amb = amb[SampleW-1:0];
    r.want.echo_obj = obj[SampleW-1:0];
    r.want.sm_amb   = sa[SampleW-1:0];
    r.want.sm_obj   = so[SampleW-1:0];
    r.want.delta    = DiffW'(so - sa);
    r.want.valid    = valid;
    r.want.status   = st;
    stim_rows.push_back(r);
  endfunction

  // Random temperature inside [lo, hi], with the bounds themselves now and then.
  // An inverted range can accept nothing, so draw anywhere in the field.
  function automatic int draw_temp(int lo, int hi);
    int roll;
    if (lo > hi) return int'($urandom_range(0, FieldHi - FieldLo)) + FieldLo;
    roll = $urandom_range(0, 19);
    if (roll == 0) return lo;
    if (roll == 1) return hi;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgEmaGain:       gain_reg = val[GainW-1:0];
      CfgAmbientMin:    amb_lo   = int'($signed(val));
      CfgAmbientMax:    amb_hi   = int'($signed(val));
      CfgObjectMin:     obj_lo   = int'($signed(val));
      CfgObjectMax:     obj_hi   = int'($signed(val));
      CfgSensorPresent: present  = val[0];
      default: ;
    endcase
  endtask

  // Hold valid low and wait until every pending reading has come back.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Offer one pair, wait for the transfer, record what must come back, then
  // either keep the burst going or drop valid for a random gap.
  task automatic send_pair(input int amb, input int obj, input logic err,
                           input logic fixed, input reading_t want);
    reading_t r;
    int       gap;
    s_axis_tdata  <= InDataW'({obj[SampleW-1:0], amb[SampleW-1:0]});
    s_axis_tuser  <= err;
    s_axis_tvalid <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    r = filter_predict(amb, obj, err);
    pending_results.push_back(fixed ? want : r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(0, 5);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: compare every transfer with the oldest pending reading and
  // stall on a pattern whose mode is redrawn at random intervals.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  reading_t seen, want_now;
  int       stall_mode, stall_left;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.echo_amb = m_axis_tdata[0 +: SampleW];
        seen.echo_obj = m_axis_tdata[SampleW +: SampleW];
        seen.sm_amb   = m_axis_tdata[2 * SampleW +: SampleW];
        seen.sm_obj   = m_axis_tdata[3 * SampleW +: SampleW];
        seen.delta    = m_axis_tdata[4 * SampleW +: DiffW];
        seen.valid    = m_axis_tuser[0];
        seen.status   = status_e'(m_axis_tuser[2:1]);
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing pending, echo_ambient %0d",
                   $time, seen.echo_amb);
        end else begin
          want_now = pending_results.pop_front();
          check_field("echo_ambient", want_now.echo_amb, seen.echo_amb);
          check_field("echo_object", want_now.echo_obj, seen.echo_obj);
          check_field("smoothed_ambient", want_now.sm_amb, seen.sm_amb);
          check_field("smoothed_object", want_now.sm_obj, seen.sm_obj);
          check_field("object_over_ambient", want_now.delta, seen.delta);
          check_field("reading_valid", want_now.valid, seen.valid);
          check_field("filter_status", want_now.status, seen.status);
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 96);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 6) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Clock, watchdog and the main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    int   p, n, mode, roll, amb, obj;
    int   alo, ahi, olo, ohi, gain;
    logic err, in_cfg;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgEmaGain;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;

    // Shadow starts at the documented reset state.
    gain_reg   = GainReset;
    amb_lo     = int'(AmbMinReset);
    amb_hi     = int'(AmbMaxReset);
    obj_lo     = int'(ObjMinReset);
    obj_hi     = int'(ObjMaxReset);
    present    = 1'b1;
    for (int i = 0; i < WinSize; i++) begin
      amb_win[i] = 0;
      obj_win[i] = 0;
    end
    ring_slot  = 0;
    primed     = 1'b0;
    amb_acc    = 0;
    obj_acc    = 0;
    mismatches = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_left = 0;

    // Rejections before seeding: error flag, each bound crossed by one, field extremes.
    add_known(2500, 3000, 1'b1, 0, 0, 1'b0, StInvalid);
    add_known(-4001, 0, 1'b0, 0, 0, 1'b0, StInvalid);
    add_known(12501, 0, 1'b0, 0, 0, 1'b0, StInvalid);
    add_known(0, -7001, 1'b0, 0, 0, 1'b0, StInvalid);
    add_known(0, 38001, 1'b0, 0, 0, 1'b0, StInvalid);
    add_known(FieldLo, FieldHi, 1'b0, 0, 0, 1'b0, StInvalid);
    // Seed, then the inclusive bounds; the median keeps the seed value.
    add_known(2000, 3000, 1'b0, 2000, 3000, 1'b1, StSeeded);
    add_known(-4000, -7000, 1'b0, 2000, 3000, 1'b1, StTrusted);
    add_known(12500, 38000, 1'b0, 2000, 3000, 1'b1, StTrusted);
    add_pair(2100, 3100, 1'b0);
    add_pair(2200, 2900, 1'b0);
    add_pair(2300, 3500, 1'b1);
    // Unity gain, then gain 0 (acts as 1), then above unity (acts as unity).
    add_reg(CfgEmaGain, GainOne);
    add_pair(-1234, 5678, 1'b0);
    add_pair(-1234, 5678, 1'b0);
    add_reg(CfgEmaGain, 0);
    add_pair(900, -900, 1'b0);
    add_reg(CfgEmaGain, GainMax);
    add_pair(-3999, 37999, 1'b0);
    // Sensor absent, with and without the error flag.
    add_reg(CfgSensorPresent, 0);
    add_pair(100, 200, 1'b0);
    add_pair(100, 200, 1'b1);
    // Inverted ambient bounds reject everything.
    add_reg(CfgSensorPresent, 1);
    add_reg(CfgAmbientMin, 5000);
    add_reg(CfgAmbientMax, -5000);
    add_pair(0, 0, 1'b0);
    // Spare index is ignored; then open both ranges to their limits.
    add_reg(CfgSpare, 12345);
    add_reg(CfgAmbientMin, -RangeLim);
    add_reg(CfgAmbientMax, RangeLim);
    add_reg(CfgObjectMin, -RangeLim);
    add_reg(CfgObjectMax, RangeLim);
    add_pair(-RangeLim, RangeLim, 1'b0);
    add_pair(RangeLim, -RangeLim, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the table; before a run of register writes let the pipe empty.
    in_cfg = 1'b0;
    foreach (stim_rows[k]) begin
      if (stim_rows[k].is_reg) begin
        if (!in_cfg) drain;
        write_reg(stim_rows[k].reg_idx, stim_rows[k].reg_val);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) begin
          cfg_we_i <= 1'b0;
          in_cfg = 1'b0;
        end
        send_pair(stim_rows[k].amb, stim_rows[k].obj, stim_rows[k].err,
                  stim_rows[k].fixed, stim_rows[k].want);
      end
    end

    // Random phases: rewrite every register while idle, then stream pairs that
    // mostly pass the range check, with flagged and arbitrary pairs mixed in.
    for (p = 0; p < RandPhases; p++) begin
      drain;
      case (p % 5)
        0:       gain = 1;
        1:       gain = GainOne;
        2:       gain = 0;
        3:       gain = $urandom_range(GainOne + 1, GainMax);
        default: gain = $urandom_range(2, GainOne - 1);
      endcase
      mode = (p < 4) ? p : $urandom_range(0, 2);
      case (mode)
        0: begin
          alo = FieldLo;
          ahi = FieldHi;
          olo = FieldLo;
          ohi = FieldHi;
        end
        1: begin
          alo = -RangeLim;
          ahi = RangeLim;
          olo = -RangeLim;
          ohi = RangeLim;
        end
        2: begin
          alo = int'($urandom_range(0, 60000)) - RangeLim;
          ahi = alo + int'($urandom_range(200, 20000));
          olo = int'($urandom_range(0, 60000)) - RangeLim;
          ohi = olo + int'($urandom_range(200, 20000));
        end
        default: begin
          // Object bounds inverted: every pair is rejected.
          alo = FieldLo;
          ahi = FieldHi;
          olo = 1500;
          ohi = -1500;
        end
      endcase
      write_reg(CfgEmaGain, CfgDataW'(gain));
      write_reg(CfgAmbientMin, CfgDataW'(alo));
      write_reg(CfgAmbientMax, CfgDataW'(ahi));
      write_reg(CfgObjectMin, CfgDataW'(olo));
      write_reg(CfgObjectMax, CfgDataW'(ohi));
      write_reg(CfgSensorPresent,
                (p == 2 || $urandom_range(0, 9) == 0) ? CfgDataW'(0) : CfgDataW'(1));
      cfg_we_i <= 1'b0;

      for (n = 0; n < PhaseItems; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          amb = draw_temp(amb_lo, amb_hi);
          obj = draw_temp(obj_lo, obj_hi);
          err = 1'b1;
        end else if (roll < 18) begin
          amb = int'($urandom_range(0, FieldHi - FieldLo)) + FieldLo;
          obj = int'($urandom_range(0, FieldHi - FieldLo)) + FieldLo;
          err = 1'($urandom_range(0, 1));
        end else begin
          amb = draw_temp(amb_lo, amb_hi);
          obj = draw_temp(obj_lo, obj_hi);
          err = 1'b0;
        end
        send_pair(amb, obj, err, 1'b0, '0);
      end
    end

    drain;
    // Give a stray extra result time to show up.
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
